[rtl/core/napt_pkg.sv]
// Shared types and constants for the TCP address and port translation engine.
package napt_pkg;

   localparam logic [7:0] FLAG_FIN    = 8'h01;
   localparam logic [7:0] FLAG_SYN    = 8'h02;
   localparam logic [7:0] FLAG_RST    = 8'h04;
   localparam logic [7:0] FLAG_ACK    = 8'h10;
   localparam logic [7:0] FLAG_FINACK = 8'h11;

   localparam logic [1:0] CSR_LOCAL_NETWORK = 2'd0;
   localparam logic [1:0] CSR_PREFIX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_PUBLIC_IP     = 2'd2;

   localparam logic [1:0] CLOSE_NONE  = 2'd0;
   localparam logic [1:0] CLOSE_FINAL = 2'd1;
   localparam logic [1:0] CLOSE_FIRST = 2'd2;

   typedef struct packed {
      logic        is_tcp;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
      logic [7:0]  tcp_flags;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic        rewrite_side;
      logic [31:0] new_ip;
      logic [15:0] new_port;
      logic        slot_freed;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  out_close;
      logic [1:0]  in_close;
      logic [15:0] port;
      logic [31:0] ip;
      logic        valid;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic is_tcp;
      logic is_out;
   } sts_type;

endpackage

[rtl/core/tcp_napt_table_engine.sv]
// Top level of the TCP address and port translation engine.
// Usage: present a packet header word on req_data and raise start; it is
// taken at a clock edge where start is high and busy is low. Exactly one
// verdict word appears on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall it and must take it in that cycle.
// A non-TCP word goes from dispatch straight to the finish state; an inbound
// word is decided by a single table read; an outbound word takes a table scan,
// one entry per cycle through the single memory read port, looking for the
// lowest matching slot and the lowest free slot.
// busy falls in the cycle the result is shown, so the next word may be
// taken then.
// Reset: a clearing pass over the whole table marks every slot free; busy
// stays high meanwhile. Configuration is written through csr_we, csr_index
// and csr_wdata at any edge, but only while idle for defined behaviour.
module tcp_napt_table_engine #(
   parameter int SLOT_COUNT = 2048,
   parameter int PORT_BASE  = 10000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  napt_pkg::req_type req_data,
   output logic              rsp_valid,
   output napt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import napt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   napt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   napt_dpath #(
      .SLOT_COUNT (SLOT_COUNT),
      .PORT_BASE  (PORT_BASE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.verdict) |-> (rsp_data.new_ip == 32'h0 &&
      rsp_data.new_port == 16'h0 && !rsp_data.slot_freed && !rsp_data.rewrite_side))
      else $error("dropped word carries rewrite data");

endmodule

[rtl/core/napt_ctrl.sv]
// Sequencer for table clearing, outbound scan and inbound lookup.
module napt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output napt_pkg::cmd_type cmd,
   input  napt_pkg::sts_type sts
);
   import napt_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_DISPATCH = 7'b0000100,
      ST_SCAN     = 7'b0001000,
      ST_DRAIN    = 7'b0010000,
      ST_LOOKUP   = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!sts.is_tcp) state_in = ST_FINISH;
            else if (sts.is_out) state_in = ST_SCAN;
            else state_in = ST_LOOKUP;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_LOOKUP: state_in = ST_FINISH;
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/core/napt_dpath.sv]
// Translation table memory, scan bookkeeping and verdict logic.
module napt_dpath #(
   parameter int SLOT_COUNT = 2048,
   parameter int PORT_BASE  = 10000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  napt_pkg::req_type req_data,
   input  napt_pkg::cmd_type cmd,
   output napt_pkg::sts_type sts,
   output logic              rsp_valid,
   output napt_pkg::rsp_type rsp_data
);
   import napt_pkg::*;

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   entry_type mem [SLOT_COUNT];
   entry_type rd_ff;

   logic [31:0]   local_ff, public_ff;
   logic [5:0]    prefix_ff;
   req_type       req_ff;
   logic [IW-1:0] cnt_ff, chk_addr_ff, hit_slot_ff, free_slot_ff;
   logic          chk_ff, hit_ff, free_ff;
   logic [1:0]    hit_ic_ff, hit_oc_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [5:0]    plen;
   logic [31:0]   mask;
   logic [15:0]   in_sub;
   logic [IW-1:0] in_slot, rd_addr, wr_addr;
   logic          in_range, in_hit, wr_en;
   entry_type     wr_data;
   rsp_type       rsp_in;
   logic [15:0]   out_port;

   always_comb begin
      plen = (prefix_ff > 6'd32) ? 6'd32 : prefix_ff;
      mask = (plen == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - plen));
   end

   assign in_sub   = req_ff.dst_port - 16'(PORT_BASE);
   assign in_slot  = in_sub[IW-1:0];
   assign in_range = ({1'b0, in_sub} < 17'(SLOT_COUNT));
   assign rd_addr  = cmd.scan ? cnt_ff : in_slot;

   assign sts.cnt_last = (cnt_ff == IW'(SLOT_COUNT - 1));
   assign sts.is_tcp   = req_ff.is_tcp;
   assign sts.is_out   = ((req_ff.src_ip & mask) == local_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff  <= '0;
         prefix_ff <= 6'd24;
         public_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOCAL_NETWORK: local_ff  <= csr_wdata;
            CSR_PREFIX_LENGTH: prefix_ff <= csr_wdata[5:0];
            CSR_PUBLIC_IP:     public_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Scan bookkeeping: keep the lowest matching slot and the lowest free slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         chk_ff  <= 1'b0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         chk_ff <= cmd.scan;
         if (cmd.load) begin
            cnt_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (cmd.clear || cmd.scan) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (chk_ff) begin
            if (rd_ff.valid && rd_ff.ip == req_ff.src_ip && rd_ff.port == req_ff.src_port
                && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!rd_ff.valid && !free_ff) free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= cnt_ff;
      if (chk_ff && rd_ff.valid && rd_ff.ip == req_ff.src_ip
          && rd_ff.port == req_ff.src_port && !hit_ff) begin
         hit_slot_ff <= chk_addr_ff;
         hit_ic_ff   <= rd_ff.in_close;
         hit_oc_ff   <= rd_ff.out_close;
      end
      if (chk_ff && !rd_ff.valid && !free_ff) free_slot_ff <= chk_addr_ff;
   end

   assign in_hit = (req_ff.dst_ip == public_ff) && in_range && rd_ff.valid;

   always_comb begin
      rsp_in   = '0;
      wr_en    = 1'b0;
      wr_addr  = in_slot;
      wr_data  = '0;
      out_port = '0;
      if (req_ff.is_tcp && sts.is_out) begin
         if (hit_ff) begin
            wr_addr      = hit_slot_ff;
            wr_data.ip   = req_ff.src_ip;
            wr_data.port = req_ff.src_port;
            out_port     = 16'(PORT_BASE) + 16'(hit_slot_ff);
            rsp_in.verdict  = 1'b1;
            rsp_in.new_ip   = public_ff;
            rsp_in.new_port = out_port;
            if (req_ff.tcp_flags == FLAG_RST) begin
               wr_en = 1'b1;
               rsp_in.slot_freed = 1'b1;
            end else if (req_ff.tcp_flags == FLAG_FIN || req_ff.tcp_flags == FLAG_FINACK) begin
               wr_en             = 1'b1;
               wr_data.valid     = 1'b1;
               wr_data.in_close  = hit_ic_ff;
               wr_data.out_close = (hit_ic_ff == CLOSE_FIRST) ? CLOSE_FINAL : CLOSE_FIRST;
            end else if (req_ff.tcp_flags == FLAG_ACK) begin
               if (hit_ic_ff == CLOSE_FINAL && hit_oc_ff == CLOSE_FIRST) begin
                  wr_en = 1'b1;
                  rsp_in.slot_freed = 1'b1;
               end
            end
         end else if (req_ff.tcp_flags == FLAG_SYN && free_ff) begin
            wr_en           = 1'b1;
            wr_addr         = free_slot_ff;
            wr_data.valid   = 1'b1;
            wr_data.ip      = req_ff.src_ip;
            wr_data.port    = req_ff.src_port;
            out_port        = 16'(PORT_BASE) + 16'(free_slot_ff);
            rsp_in.verdict  = 1'b1;
            rsp_in.new_ip   = public_ff;
            rsp_in.new_port = out_port;
         end
      end else if (req_ff.is_tcp && in_hit) begin
         rsp_in.verdict      = 1'b1;
         rsp_in.rewrite_side = 1'b1;
         rsp_in.new_ip       = rd_ff.ip;
         rsp_in.new_port     = rd_ff.port;
         wr_data.ip          = rd_ff.ip;
         wr_data.port        = rd_ff.port;
         if (req_ff.tcp_flags == FLAG_RST) begin
            wr_en = 1'b1;
            rsp_in.slot_freed = 1'b1;
         end else if (req_ff.tcp_flags == FLAG_FIN || req_ff.tcp_flags == FLAG_FINACK) begin
            wr_en             = 1'b1;
            wr_data.valid     = 1'b1;
            wr_data.out_close = rd_ff.out_close;
            wr_data.in_close  = (rd_ff.out_close == CLOSE_FIRST) ? CLOSE_FINAL : CLOSE_FIRST;
         end else if (req_ff.tcp_flags == FLAG_ACK) begin
            if (rd_ff.in_close == CLOSE_FIRST && rd_ff.out_close == CLOSE_FINAL) begin
               wr_en = 1'b1;
               rsp_in.slot_freed = 1'b1;
            end
         end
      end
   end

   // Single write port shared by the clearing pass and the final update.
   always_ff @(posedge clock) begin
      if (cmd.clear) mem[cnt_ff] <= '0;
      else if (cmd.finish && wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.finish;
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[tb/napt_table_checker.sv]
// Checker for the translation engine: predicts each verdict word and compares it.
module napt_table_checker #(
   parameter int SLOT_COUNT = 2048,
   parameter int PORT_BASE  = 10000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  napt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  napt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                pending_verdicts
);
   import napt_pkg::*;

   logic [31:0] local_net;
   logic [5:0]  prefix_len;
   logic [31:0] public_addr;

   logic        map_valid [SLOT_COUNT];
   logic [31:0] map_ip    [SLOT_COUNT];
   logic [15:0] map_port  [SLOT_COUNT];
   logic [1:0]  in_mark   [SLOT_COUNT];
   logic [1:0]  out_mark  [SLOT_COUNT];

   rsp_type verdict_queue[$];

   assign pending_verdicts = verdict_queue.size();

   function automatic logic [31:0] inside_mask();
      int p;
      p = (prefix_len > 32) ? 32 : prefix_len;
      if (p == 0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - p);
   endfunction

   function automatic void release_map(int s);
      map_valid[s] = 1'b0;
      in_mark[s]   = CLOSE_NONE;
      out_mark[s]  = CLOSE_NONE;
   endfunction

   function automatic rsp_type translate(req_type w);
      rsp_type r;
      int      s;
      int      hit;
      logic [15:0] idx;
      r   = '0;
      hit = -1;
      if (!w.is_tcp) return r;
      if ((w.src_ip & inside_mask()) == local_net) begin
         for (s = 0; s < SLOT_COUNT; s++)
            if (hit < 0 && map_valid[s] && map_ip[s] == w.src_ip &&
                map_port[s] == w.src_port)
               hit = s;
         if (hit >= 0) begin
            if (w.tcp_flags == FLAG_RST) begin
               release_map(hit);
               r.slot_freed = 1'b1;
            end else if (w.tcp_flags == FLAG_FIN || w.tcp_flags == FLAG_FINACK) begin
               out_mark[hit] = (in_mark[hit] == CLOSE_FIRST) ? CLOSE_FINAL : CLOSE_FIRST;
            end else if (w.tcp_flags == FLAG_ACK) begin
               if (in_mark[hit] == CLOSE_FINAL && out_mark[hit] == CLOSE_FIRST) begin
                  release_map(hit);
                  r.slot_freed = 1'b1;
               end
            end
         end else begin
            if (w.tcp_flags != FLAG_SYN) return r;
            for (s = 0; s < SLOT_COUNT; s++)
               if (hit < 0 && !map_valid[s]) hit = s;
            if (hit < 0) return r;
            map_valid[hit] = 1'b1;
            map_ip[hit]    = w.src_ip;
            map_port[hit]  = w.src_port;
            in_mark[hit]   = CLOSE_NONE;
            out_mark[hit]  = CLOSE_NONE;
         end
         r.verdict  = 1'b1;
         r.new_ip   = public_addr;
         r.new_port = 16'(PORT_BASE + hit);
         return r;
      end
      idx = w.dst_port - 16'(PORT_BASE);
      if (w.dst_ip != public_addr || idx >= SLOT_COUNT || !map_valid[idx]) return r;
      r.verdict      = 1'b1;
      r.rewrite_side = 1'b1;
      r.new_ip       = map_ip[idx];
      r.new_port     = map_port[idx];
      if (w.tcp_flags == FLAG_RST) begin
         release_map(idx);
         r.slot_freed = 1'b1;
      end else if (w.tcp_flags == FLAG_FIN || w.tcp_flags == FLAG_FINACK) begin
         in_mark[idx] = (out_mark[idx] == CLOSE_FIRST) ? CLOSE_FINAL : CLOSE_FIRST;
      end else if (w.tcp_flags == FLAG_ACK) begin
         if (in_mark[idx] == CLOSE_FIRST && out_mark[idx] == CLOSE_FINAL) begin
            release_map(idx);
            r.slot_freed = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         local_net   <= '0;
         prefix_len  <= 6'd24;
         public_addr <= '0;
         fail_count  <= 0;
         verdict_queue.delete();
         for (int s = 0; s < SLOT_COUNT; s++) begin
            map_valid[s] = 1'b0;
            in_mark[s]   = CLOSE_NONE;
            out_mark[s]  = CLOSE_NONE;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOCAL_NETWORK: local_net <= csr_wdata;
               CSR_PREFIX_LENGTH: prefix_len <= csr_wdata[5:0];
               CSR_PUBLIC_IP:     public_addr <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict word, expected none, actual %p", $time,
                        rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: verdict mismatch, expected %p, actual %p", $time, want,
                           rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) verdict_queue.push_back(translate(req_data));
      end
   end
endmodule

[tb/tb_tcp_napt_table_engine.sv]
// Top of the translation engine testbench: stimulus, clock, reset and verdict.
module tb_tcp_napt_table_engine;
   import napt_pkg::*;

   localparam int SLOTS = 2048;
   localparam int BASE  = 10000;
   localparam longint CYCLE_LIMIT = 20_000_000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending_verdicts;
   longint      cycle_count;

   logic [31:0] cur_net;
   logic [31:0] cur_pub;
   logic [5:0]  cur_prefix;
   logic [31:0] flow_ip [8];
   logic [15:0] flow_port [8];

   tcp_napt_table_engine #(.SLOT_COUNT(SLOTS), .PORT_BASE(BASE)) i_dut (.*);

   napt_table_checker #(.SLOT_COUNT(SLOTS), .PORT_BASE(BASE)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic pause_between();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_word(req_type w);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      start    <= 1'b0;
      req_data <= req_type'({$urandom, $urandom, $urandom});
      // the block stays busy after an accept, so this edge costs no throughput
      @(posedge clock);
      pause_between();
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      // let the block finish any word still in flight
      while (pending_verdicts != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_setting(logic [31:0] net, logic [5:0] pfx, logic [31:0] pub);
      logic [31:0] m;
      m = (pfx == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - ((pfx > 32) ? 32 : pfx)));
      cur_net    = net & m;
      cur_prefix = pfx;
      cur_pub    = pub;
      write_reg(CSR_LOCAL_NETWORK, cur_net);
      write_reg(CSR_PREFIX_LENGTH, {26'd0, pfx});
      write_reg(CSR_PUBLIC_IP, pub);
   endtask

   function automatic logic [7:0] pick_flags();
      case ($urandom_range(0, 9))
         0, 1: return FLAG_SYN;
         2: return FLAG_RST;
         3: return FLAG_FIN;
         4: return FLAG_FINACK;
         5, 6: return FLAG_ACK;
         7: return 8'h18;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type flow_word(bit outward, int f, logic [7:0] fl);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom});
      w.is_tcp    = 1'b1;
      w.tcp_flags = fl;
      if (outward) begin
         w.src_ip   = flow_ip[f];
         w.src_port = flow_port[f];
      end else begin
         w.src_ip   = ~cur_net;
         w.dst_ip   = cur_pub;
         w.dst_port = 16'(BASE + $urandom_range(0, 9));
         if ($urandom_range(0, 7) == 0) w.dst_port = 16'($urandom);
      end
      return w;
   endfunction

   task automatic new_flows();
      for (int f = 0; f < 8; f++) begin
         flow_ip[f]   = (cur_net & ~(32'hFFFF_FFFF << (32 - 8))) | (32'($urandom) & 32'h0F);
         flow_ip[f]   = cur_net | (($urandom & 32'hFF) & ((cur_prefix >= 32) ? 32'h0 :
                        ~(32'hFFFF_FFFF << (32 - cur_prefix)) | 32'h0));
         flow_port[f] = (f == 0) ? 16'hFFFF : (f == 1) ? 16'h0000 : 16'($urandom);
      end
      flow_port[3] = flow_port[2];
   endtask

   initial begin
      req_type w;
      int f;
      cycle_count = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_LOCAL_NETWORK;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: set the settings, then a full open and close in both orders
      set_setting(32'h0A00_0000, 6'd24, 32'hC633_6401);
      new_flows();
      send_word(flow_word(1, 0, FLAG_SYN));
      send_word(flow_word(1, 1, FLAG_SYN));
      send_word(flow_word(1, 0, FLAG_SYN));
      send_word(flow_word(1, 2, FLAG_ACK));
      w = flow_word(0, 0, FLAG_ACK); w.dst_port = 16'(BASE); send_word(w);
      w = flow_word(0, 0, 8'h18); w.dst_port = 16'(BASE + 1); send_word(w);
      send_word(flow_word(1, 0, FLAG_FIN));
      w = flow_word(0, 0, FLAG_FINACK); w.dst_port = 16'(BASE); send_word(w);
      send_word(flow_word(1, 0, FLAG_ACK));
      w = flow_word(0, 0, FLAG_FIN); w.dst_port = 16'(BASE + 1); send_word(w);
      send_word(flow_word(1, 1, FLAG_FINACK));
      w = flow_word(0, 0, FLAG_ACK); w.dst_port = 16'(BASE + 1); send_word(w);
      send_word(flow_word(1, 2, FLAG_SYN));
      send_word(flow_word(1, 2, FLAG_RST));
      w = flow_word(0, 0, FLAG_SYN); w.dst_port = 16'(BASE - 1); send_word(w);
      w = flow_word(0, 0, FLAG_SYN); w.dst_port = 16'(BASE + SLOTS); send_word(w);
      w = flow_word(0, 0, FLAG_SYN); w.is_tcp = 1'b0; send_word(w);
      w = '1; send_word(w);
      w = '0; w.is_tcp = 1'b1; send_word(w);

      // random phases over several settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_setting(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
            1: set_setting(32'h0, 6'd0, 32'h0);
            2: set_setting($urandom, 6'd63, $urandom);
            3: set_setting($urandom, 6'($urandom_range(1, 31)), $urandom);
            default: set_setting($urandom, 6'($urandom_range(8, 28)), $urandom);
         endcase
         new_flows();
         for (int n = 0; n < 45; n++) begin
            f = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
               0: send_word(req_type'({$urandom, $urandom, $urandom}));
               1, 2, 3: begin
                  w = flow_word(0, f, pick_flags());
                  send_word(w);
               end
               default: send_word(flow_word(1, f, pick_flags()));
            endcase
         end
      end

      while (pending_verdicts != 0) @(posedge clock);
      repeat (SLOTS + 20) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
